@@ src/tlca_pkg.sv @@
// Shared constants and codes for the tree path-length engine.
package tlca_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int LEVELS_DEF    = 10;

	// Fixed widths of the request and result fields.
	localparam int NODE_W  = 11;
	localparam int OP_W    = 2;
	localparam int OUT_MAX = (1 << NODE_W) - 1;

	typedef enum logic [OP_W-1:0] {
		OP_EDGE  = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic {
		ST_OK     = 1'b0,
		ST_REJECT = 1'b1
	} status_t;

endpackage

@@ src/tree_lca_path_length.sv @@
// Top level of the tree path-length engine: sequencer around the adjacency, node and stack RAMs.
//
//   channel   direction  handshake           payload
//   in        request    in_valid/in_stall   op, node_a, node_b
//   out       result     out_valid/out_stall status, ancestor, path_nodes
//   cfg       write      cfg_we              cfg_data (node_count)
//
// One request is worked at a time; every memory has one read port with registered read data.
// Add edge: read the head entry, write the slot and relink any old tail, once for each direction.
// Query: read both rows, lift the deeper node, climb both to the meeting node, read its depth.
// Build: clear the node rows, walk depth-first from node 1, then fill the lifting table by level.
// After reset a clearing pass empties the adjacency heads; in_stall is high.
// A finished result sits in the output register, so a new request is taken while it waits.
module tree_lca_path_length #(
	parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEF,
	parameter int LEVELS    = tlca_pkg::LEVELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tlca_pkg::NODE_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tlca_pkg::OP_W-1:0]   op,
	input  logic [tlca_pkg::NODE_W-1:0] node_a,
	input  logic [tlca_pkg::NODE_W-1:0] node_b,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [tlca_pkg::NODE_W-1:0] ancestor,
	output logic [tlca_pkg::NODE_W-1:0] path_nodes
);

	localparam int NW         = $clog2(MAX_NODES + 1);
	localparam int DW         = $clog2(MAX_NODES);
	localparam int EDGE_SLOTS = 2 * (MAX_NODES - 1);
	localparam int SW         = $clog2(EDGE_SLOTS + 1);
	localparam int SIW        = $clog2(EDGE_SLOTS);
	localparam int SAW        = $clog2(MAX_NODES);
	localparam int LIW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW         = (NW > tlca_pkg::NODE_W) ? NW : tlca_pkg::NODE_W;
	localparam int CNTW       = ((DW + 2) > tlca_pkg::NODE_W) ? (DW + 2) : tlca_pkg::NODE_W;

	typedef struct packed {
		logic                       vis;
		logic [DW-1:0]              depth;
		logic [LEVELS-1:0][NW-1:0]  anc;
	} row_t;

	typedef struct packed {
		logic [SW-1:0] head;
		logic [SW-1:0] tail;
	} head_t;

	typedef struct packed {
		logic [NW-1:0] node;
		logic [SW-1:0] cur;
	} stk_t;

	typedef enum logic [4:0] {
		S_RST_CLR, S_IDLE,
		S_E_RD, S_E_WR, S_E_LINK,
		S_B_CLR, S_B_HD, S_B_INIT,
		S_W_CUR, S_W_ADJ, S_W_VIS, S_W_POPRD, S_W_POP,
		S_F_START, S_F_RDI, S_F_RDX, S_F_WR,
		S_Q_RDA, S_Q_RDB, S_Q_ORDER, S_Q_LIFT, S_Q_LRD, S_Q_LDAT,
		S_Q_EQ, S_Q_CMP, S_Q_RX, S_Q_RY, S_Q_RYD, S_Q_RDANC, S_Q_CNT,
		S_RESP
	} state_t;

	state_t              state_q;
	logic [NW-1:0]       node_count_q;
	logic                built_q;
	logic [SW-1:0]       slots_q;
	logic [NW-1:0]       clr_q;
	logic [NW-1:0]       a_q, b_q;
	logic [NW-1:0]       from_q, dest_q;
	logic                half_q;
	logic [SW-1:0]       tail_old_q;
	logic [NW-1:0]       sp_q;
	logic [NW-1:0]       top_node_q;
	logic [SW-1:0]       top_cur_q;
	logic [NW-1:0]       tgt_q;
	logic [LIW-1:0]      lvl_q;
	logic [NW-1:0]       i_q;
	row_t                rowi_q, rx_q, ry_q;
	logic [NW-1:0]       x_q, y_q, anc_q;
	logic [DW-1:0]       da_q, db_q;
	logic [LEVELS-1:0]   diff_q;
	logic                res_status_q;
	logic [NW-1:0]       res_anc_q;
	logic [tlca_pkg::NODE_W-1:0] res_cnt_q;
	logic                out_valid_q, status_q;
	logic [tlca_pkg::NODE_W-1:0] ancestor_q, path_nodes_q;

	// Memory ports.
	logic          head_we;
	logic [NW-1:0] head_waddr, head_raddr;
	head_t         head_wdata, head_rd;
	logic          nxt_we;
	logic [SIW-1:0] nxt_waddr, adj_raddr, tgt_waddr;
	logic [SW-1:0] nxt_wdata, nxt_rd;
	logic          tgt_we;
	logic [NW-1:0] tgt_wdata, tgt_rd;
	logic          node_we;
	logic [NW-1:0] node_waddr, node_raddr;
	row_t          node_wdata, node_rd;
	logic          stk_we;
	logic [SAW-1:0] stk_waddr, stk_raddr;
	stk_t          stk_wdata, stk_rd;

	// Request decode.
	logic a_ok, b_ok, slots_room;
	logic [CW-1:0] cfg_v;
	logic [NW-1:0] cfg_clamped;
	logic [DW+1:0] cnt_sum, cnt_twice;
	logic [CNTW-1:0] cnt_val;

	assign a_ok = (node_a != '0) && (CW'(node_a) <= CW'(node_count_q));
	assign b_ok = (node_b != '0) && (CW'(node_b) <= CW'(node_count_q));
	assign slots_room = ((SW+1)'(slots_q) + (SW+1)'(2)) <= (SW+1)'(EDGE_SLOTS);

	always_comb begin
		cfg_v = CW'(cfg_data);
		if (cfg_v == '0) begin
			cfg_v = CW'(1);
		end
		if (cfg_v > CW'(MAX_NODES)) begin
			cfg_v = CW'(MAX_NODES);
		end
		cfg_clamped = NW'(cfg_v);
	end

	// Path node count from the three depths, floored at zero; S_Q_CNT saturates it to the result field.
	always_comb begin
		cnt_sum   = (DW+2)'(da_q) + (DW+2)'(db_q) + (DW+2)'(1);
		cnt_twice = (DW+2)'(node_rd.depth) << 1;
		cnt_val   = (cnt_sum >= cnt_twice) ? CNTW'(cnt_sum - cnt_twice) : '0;
	end

	tlca_ram #(.WIDTH($bits(head_t)), .DEPTH(MAX_NODES + 1)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rd)
	);

	tlca_ram #(.WIDTH(SW), .DEPTH(EDGE_SLOTS)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(adj_raddr), .rdata(nxt_rd)
	);

	tlca_ram #(.WIDTH(NW), .DEPTH(EDGE_SLOTS)) u_target (
		.clk(clk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
		.raddr(adj_raddr), .rdata(tgt_rd)
	);

	tlca_ram #(.WIDTH($bits(row_t)), .DEPTH(MAX_NODES + 1)) u_node (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rd)
	);

	tlca_ram #(.WIDTH($bits(stk_t)), .DEPTH(MAX_NODES)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rd)
	);

	// Memory addressing per state.
	always_comb begin
		head_we    = 1'b0;
		head_waddr = from_q;
		head_wdata = '0;
		head_raddr = from_q;
		nxt_we     = 1'b0;
		nxt_waddr  = slots_q[SIW-1:0];
		nxt_wdata  = '0;
		tgt_we     = 1'b0;
		tgt_waddr  = slots_q[SIW-1:0];
		tgt_wdata  = dest_q;
		adj_raddr  = SIW'(top_cur_q - SW'(1));
		node_we    = 1'b0;
		node_waddr = i_q;
		node_wdata = '0;
		node_raddr = i_q;
		stk_we     = 1'b0;
		stk_waddr  = SAW'(sp_q - NW'(1));
		stk_wdata  = '{node: top_node_q, cur: top_cur_q};
		stk_raddr  = SAW'(sp_q - NW'(1));
		case (state_q)
			S_RST_CLR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
			end
			S_E_WR: begin
				head_we         = 1'b1;
				head_wdata.tail = slots_q + SW'(1);
				head_wdata.head = (head_rd.tail == '0) ? (slots_q + SW'(1)) : head_rd.head;
				tgt_we          = 1'b1;
				nxt_we          = 1'b1;
			end
			S_E_LINK: begin
				// The old tail slot now points at the slot just appended.
				nxt_we    = 1'b1;
				nxt_waddr = SIW'(tail_old_q - SW'(1));
				nxt_wdata = slots_q;
			end
			S_B_CLR: begin
				node_we    = 1'b1;
				node_waddr = clr_q;
			end
			S_B_HD: begin
				head_raddr = NW'(1);
			end
			S_B_INIT: begin
				node_we        = 1'b1;
				node_waddr     = NW'(1);
				node_wdata.vis = 1'b1;
			end
			S_W_ADJ: begin
				node_raddr = tgt_rd;
				head_raddr = tgt_rd;
			end
			S_W_VIS: begin
				if (!node_rd.vis) begin
					node_we           = 1'b1;
					node_waddr        = tgt_q;
					node_wdata.vis    = 1'b1;
					node_wdata.depth  = DW'(sp_q);
					node_wdata.anc[0] = top_node_q;
					stk_we            = 1'b1;
				end
			end
			S_F_RDX: begin
				node_raddr = node_rd.anc[LIW'(lvl_q - LIW'(1))];
			end
			S_F_WR: begin
				node_we            = 1'b1;
				node_wdata         = rowi_q;
				node_wdata.anc[lvl_q] = node_rd.anc[LIW'(lvl_q - LIW'(1))];
			end
			S_Q_RDA:   node_raddr = a_q;
			S_Q_RDB:   node_raddr = b_q;
			S_Q_LRD:   node_raddr = x_q;
			S_Q_RX:    node_raddr = x_q;
			S_Q_RY:    node_raddr = y_q;
			S_Q_RDANC: node_raddr = anc_q;
			default: begin
			end
		endcase
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign ancestor   = ancestor_q;
	assign path_nodes = path_nodes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_RST_CLR;
			node_count_q <= NW'(1);
			built_q      <= 1'b0;
			slots_q      <= '0;
			clr_q        <= '0;
			sp_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_clamped;
				built_q      <= 1'b0;
			end
			// While a result is being handed over the output register is reloaded below.
			if (out_valid_q && !out_stall && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_RST_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(MAX_NODES)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						a_q          <= NW'(node_a);
						b_q          <= NW'(node_b);
						from_q       <= NW'(node_a);
						dest_q       <= NW'(node_b);
						half_q       <= 1'b0;
						res_status_q <= tlca_pkg::ST_REJECT;
						res_anc_q    <= '0;
						res_cnt_q    <= '0;
						case (tlca_pkg::op_t'(op))
							tlca_pkg::OP_EDGE: begin
								state_q <= (a_ok && b_ok && slots_room) ? S_E_RD : S_RESP;
							end
							tlca_pkg::OP_BUILD: begin
								clr_q   <= '0;
								state_q <= S_B_CLR;
							end
							tlca_pkg::OP_QUERY: begin
								state_q <= (built_q && a_ok && b_ok) ? S_Q_RDA : S_RESP;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_E_RD: state_q <= S_E_WR;
				S_E_WR: begin
					tail_old_q <= head_rd.tail;
					slots_q    <= slots_q + SW'(1);
					if (head_rd.tail != '0) begin
						state_q <= S_E_LINK;
					end else if (!half_q) begin
						half_q  <= 1'b1;
						from_q  <= dest_q;
						dest_q  <= from_q;
						state_q <= S_E_RD;
					end else begin
						res_status_q <= tlca_pkg::ST_OK;
						state_q      <= S_RESP;
					end
				end
				S_E_LINK: begin
					if (!half_q) begin
						half_q  <= 1'b1;
						from_q  <= dest_q;
						dest_q  <= from_q;
						state_q <= S_E_RD;
					end else begin
						res_status_q <= tlca_pkg::ST_OK;
						state_q      <= S_RESP;
					end
				end
				S_B_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(MAX_NODES)) begin
						state_q <= S_B_HD;
					end
				end
				S_B_HD: state_q <= S_B_INIT;
				S_B_INIT: begin
					top_node_q <= NW'(1);
					top_cur_q  <= head_rd.head;
					sp_q       <= NW'(1);
					state_q    <= S_W_CUR;
				end
				S_W_CUR: begin
					if (sp_q == '0) begin
						state_q <= S_F_START;
					end else if (top_cur_q == '0) begin
						// Neighbor list exhausted: drop back to the parent.
						sp_q    <= sp_q - NW'(1);
						state_q <= (sp_q == NW'(1)) ? S_F_START : S_W_POPRD;
					end else begin
						state_q <= S_W_ADJ;
					end
				end
				S_W_ADJ: begin
					top_cur_q <= nxt_rd;
					tgt_q     <= tgt_rd;
					state_q   <= S_W_VIS;
				end
				S_W_VIS: begin
					if (!node_rd.vis) begin
						top_node_q <= tgt_q;
						top_cur_q  <= head_rd.head;
						sp_q       <= sp_q + NW'(1);
					end
					state_q <= S_W_CUR;
				end
				S_W_POPRD: state_q <= S_W_POP;
				S_W_POP: begin
					top_node_q <= stk_rd.node;
					top_cur_q  <= stk_rd.cur;
					state_q    <= S_W_CUR;
				end
				S_F_START: begin
					lvl_q <= LIW'(1);
					i_q   <= NW'(1);
					if (LEVELS == 1) begin
						built_q      <= 1'b1;
						res_status_q <= tlca_pkg::ST_OK;
						state_q      <= S_RESP;
					end else begin
						state_q <= S_F_RDI;
					end
				end
				S_F_RDI: state_q <= S_F_RDX;
				S_F_RDX: begin
					rowi_q  <= node_rd;
					state_q <= S_F_WR;
				end
				S_F_WR: begin
					if (i_q == NW'(MAX_NODES)) begin
						i_q <= NW'(1);
						if (lvl_q == LIW'(LEVELS - 1)) begin
							built_q      <= 1'b1;
							res_status_q <= tlca_pkg::ST_OK;
							state_q      <= S_RESP;
						end else begin
							lvl_q   <= lvl_q + LIW'(1);
							state_q <= S_F_RDI;
						end
					end else begin
						i_q     <= i_q + NW'(1);
						state_q <= S_F_RDI;
					end
				end
				S_Q_RDA: state_q <= S_Q_RDB;
				S_Q_RDB: begin
					rx_q    <= node_rd;
					state_q <= S_Q_ORDER;
				end
				S_Q_ORDER: begin
					da_q  <= rx_q.depth;
					db_q  <= node_rd.depth;
					lvl_q <= '0;
					if (rx_q.depth < node_rd.depth) begin
						x_q    <= b_q;
						y_q    <= a_q;
						rx_q   <= node_rd;
						ry_q   <= rx_q;
						diff_q <= LEVELS'(node_rd.depth - rx_q.depth);
					end else begin
						x_q    <= a_q;
						y_q    <= b_q;
						ry_q   <= node_rd;
						diff_q <= LEVELS'(rx_q.depth - node_rd.depth);
					end
					state_q <= S_Q_LIFT;
				end
				S_Q_LIFT: begin
					if (diff_q[lvl_q]) begin
						x_q     <= rx_q.anc[lvl_q];
						state_q <= S_Q_LRD;
					end else if (lvl_q == LIW'(LEVELS - 1)) begin
						state_q <= S_Q_EQ;
					end else begin
						lvl_q <= lvl_q + LIW'(1);
					end
				end
				S_Q_LRD: state_q <= S_Q_LDAT;
				S_Q_LDAT: begin
					rx_q <= node_rd;
					if (lvl_q == LIW'(LEVELS - 1)) begin
						state_q <= S_Q_EQ;
					end else begin
						lvl_q   <= lvl_q + LIW'(1);
						state_q <= S_Q_LIFT;
					end
				end
				S_Q_EQ: begin
					lvl_q <= LIW'(LEVELS - 1);
					if (x_q == y_q) begin
						anc_q   <= x_q;
						state_q <= S_Q_RDANC;
					end else begin
						state_q <= S_Q_CMP;
					end
				end
				S_Q_CMP: begin
					if (rx_q.anc[lvl_q] != ry_q.anc[lvl_q]) begin
						x_q     <= rx_q.anc[lvl_q];
						y_q     <= ry_q.anc[lvl_q];
						state_q <= S_Q_RX;
					end else if (lvl_q == '0) begin
						anc_q   <= rx_q.anc[0];
						state_q <= S_Q_RDANC;
					end else begin
						lvl_q <= lvl_q - LIW'(1);
					end
				end
				S_Q_RX: state_q <= S_Q_RY;
				S_Q_RY: begin
					rx_q    <= node_rd;
					state_q <= S_Q_RYD;
				end
				S_Q_RYD: begin
					ry_q <= node_rd;
					if (lvl_q == '0) begin
						anc_q   <= rx_q.anc[0];
						state_q <= S_Q_RDANC;
					end else begin
						lvl_q   <= lvl_q - LIW'(1);
						state_q <= S_Q_CMP;
					end
				end
				S_Q_RDANC: state_q <= S_Q_CNT;
				S_Q_CNT: begin
					res_status_q <= tlca_pkg::ST_OK;
					res_anc_q    <= anc_q;
					res_cnt_q    <= (cnt_val > CNTW'(tlca_pkg::OUT_MAX)) ?
						tlca_pkg::NODE_W'(tlca_pkg::OUT_MAX) : tlca_pkg::NODE_W'(cnt_val);
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_status_q;
						ancestor_q   <= tlca_pkg::NODE_W'(res_anc_q);
						path_nodes_q <= res_cnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// A rejected request never reports an ancestor or a path length.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (ancestor_q == '0 && path_nodes_q == '0))
		else $error("rejected request carries a nonzero result");

	a_slots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(SW+1)'(slots_q) <= (SW+1)'(EDGE_SLOTS))
		else $error("edge slot count beyond the adjacency store");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= NW'(MAX_NODES))
		else $error("walk stack pointer beyond the stack depth");

	// A query only starts against a table that has been built.
	a_query_built: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_RDA) |-> built_q)
		else $error("query started on an unbuilt table");
`endif

endmodule

@@ src/tlca_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module tlca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the tree path-length engine, with scoreboard and stimulus.
`timescale 1ns / 1ps

import tlca_pkg::*;

typedef struct {
	logic                status;
	logic [NODE_W-1:0]   ancestor;
	logic [NODE_W-1:0]   path_nodes;
} path_result_t;

class path_scoreboard;
	localparam int NODES = MAX_NODES_DEF;
	localparam int LVLS  = LEVELS_DEF;
	localparam int SLOTS = 2 * (NODES - 1);

	int unsigned node_lim;
	int unsigned head_of[NODES+1];
	int unsigned tail_of[NODES+1];
	int unsigned next_of[SLOTS];
	int unsigned dest_of[SLOTS];
	int unsigned slots_used;
	int unsigned depth_of[NODES+1];
	int unsigned lift[NODES+1][LVLS];
	bit          reached[NODES+1];
	int unsigned walk_node[NODES+1];
	int unsigned walk_cur[NODES+1];
	bit          built;
	path_result_t pending[$];
	int          errors;

	function new();
		node_lim = 1;
		slots_used = 0;
		built = 0;
		errors = 0;
		foreach (head_of[i]) begin
			head_of[i] = 0;
			tail_of[i] = 0;
			depth_of[i] = 0;
			reached[i] = 0;
			for (int j = 0; j < LVLS; j++)
				lift[i][j] = 0;
		end
	endfunction

	function void set_node_limit(logic [NODE_W-1:0] v);
		int unsigned n;
		n = v;
		if (n == 0)
			n = 1;
		if (n > NODES)
			n = NODES;
		node_lim = n;
		built = 0;
	endfunction

	function void link(int unsigned from, int unsigned to);
		int unsigned s;
		s = slots_used;
		dest_of[s] = to;
		next_of[s] = 0;
		if (tail_of[from] == 0)
			head_of[from] = s + 1;
		else
			next_of[tail_of[from] - 1] = s + 1;
		tail_of[from] = s + 1;
		slots_used = s + 1;
	endfunction

	function void walk_tree();
		int unsigned sp, top, cur, t, here;
		foreach (depth_of[i]) begin
			depth_of[i] = 0;
			reached[i] = 0;
			for (int j = 0; j < LVLS; j++)
				lift[i][j] = 0;
		end
		reached[1] = 1;
		walk_node[0] = 1;
		walk_cur[0] = head_of[1];
		sp = 1;
		while (sp > 0) begin
			top = sp - 1;
			cur = walk_cur[top];
			if (cur == 0 || cur > SLOTS) begin
				sp--;
				continue;
			end
			walk_cur[top] = next_of[cur - 1];
			t = dest_of[cur - 1];
			if (t > NODES || reached[t])
				continue;
			here = walk_node[top];
			reached[t] = 1;
			lift[t][0] = here;
			depth_of[t] = depth_of[here] + 1;
			if (sp < NODES + 1) begin
				walk_node[sp] = t;
				walk_cur[sp] = head_of[t];
				sp++;
			end
		end
		for (int j = 1; j < LVLS; j++)
			for (int i = 1; i <= NODES; i++)
				lift[i][j] = lift[lift[i][j-1]][j-1];
		built = 1;
	endfunction

	function int unsigned meet(int unsigned x, int unsigned y);
		int unsigned diff, t;
		if (depth_of[x] < depth_of[y]) begin
			t = x;
			x = y;
			y = t;
		end
		diff = depth_of[x] - depth_of[y];
		for (int i = 0; i < LVLS; i++)
			if ((diff >> i) & 1)
				x = lift[x][i];
		if (x == y)
			return x;
		for (int i = LVLS - 1; i >= 0; i--)
			if (lift[x][i] != lift[y][i]) begin
				x = lift[x][i];
				y = lift[y][i];
			end
		return lift[x][0];
	endfunction

	function void note_request(logic [OP_W-1:0] op, logic [NODE_W-1:0] a,
			logic [NODE_W-1:0] b);
		path_result_t r;
		bit a_ok, b_ok;
		int unsigned anc, sum, twice, cnt;
		r.status = ST_REJECT;
		r.ancestor = '0;
		r.path_nodes = '0;
		a_ok = (a >= 1 && a <= node_lim);
		b_ok = (b >= 1 && b <= node_lim);
		if (op == OP_EDGE) begin
			if (a_ok && b_ok && slots_used + 2 <= SLOTS) begin
				link(a, b);
				link(b, a);
				r.status = ST_OK;
			end
		end else if (op == OP_BUILD) begin
			walk_tree();
			r.status = ST_OK;
		end else if (op == OP_QUERY) begin
			if (built && a_ok && b_ok) begin
				anc = meet(a, b);
				sum = depth_of[a] + depth_of[b] + 1;
				twice = 2 * depth_of[anc];
				cnt = (sum >= twice) ? sum - twice : 0;
				if (cnt > OUT_MAX)
					cnt = OUT_MAX;
				r.status = ST_OK;
				r.ancestor = NODE_W'(anc);
				r.path_nodes = NODE_W'(cnt);
			end
		end
		pending.insert(pending.size(), r);
	endfunction

	function void check_result(logic st, logic [NODE_W-1:0] anc, logic [NODE_W-1:0] pn);
		path_result_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result status=%0d ancestor=%0d path_nodes=%0d",
				$time, st, anc, pn);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (st !== e.status) begin
			$display("%0t: status expected %0d actual %0d", $time, e.status, st);
			errors++;
		end
		if (anc !== e.ancestor) begin
			$display("%0t: ancestor expected %0d actual %0d", $time, e.ancestor, anc);
			errors++;
		end
		if (pn !== e.path_nodes) begin
			$display("%0t: path_nodes expected %0d actual %0d", $time, e.path_nodes, pn);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 200000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [NODE_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [OP_W-1:0]   op;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;
	logic              out_valid;
	logic              out_stall;
	logic              status;
	logic [NODE_W-1:0] ancestor;
	logic [NODE_W-1:0] path_nodes;

	path_scoreboard sb;
	int requests_sent;
	int results_seen = 0;
	int quiet_cycles = 0;
	int perm[$];

	tree_lca_path_length u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .node_a(node_a), .node_b(node_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .ancestor(ancestor), .path_nodes(path_nodes)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	// Valid stays high into the next request when there is no gap.
	task automatic send(logic [OP_W-1:0] o, int a, int b);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		node_a <= a[NODE_W-1:0];
		node_b <= b[NODE_W-1:0];
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		sb.note_request(o, a[NODE_W-1:0], b[NODE_W-1:0]);
		requests_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(int v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= v[NODE_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_node_limit(v[NODE_W-1:0]);
	endtask

	function automatic int pick_node(int n);
		case ($urandom_range(0, 19))
			0: return 0;
			1: return n + 1 + $urandom_range(0, 2046 - n);
			2: return 2047;
			default: return $urandom_range(1, n);
		endcase
	endfunction

	// Shuffled numbering so tree edges arrive in random order and shape.
	task automatic grow_tree(int n, int edges, int reach);
		int k, j, p;
		perm = {};
		for (k = 1; k <= n; k++)
			perm.insert(perm.size(), k);
		perm.shuffle();
		for (k = 0; k < perm.size(); k++)
			if (perm[k] == 1) begin
				perm[k] = perm[0];
				perm[0] = 1;
			end
		for (k = 1; k < n && k <= edges; k++) begin
			j = (reach > 0 && k > reach) ? $urandom_range(k - reach, k - 1)
				: $urandom_range(0, k - 1);
			p = perm[j];
			if ($urandom_range(0, 1))
				send(OP_EDGE, p, perm[k]);
			else
				send(OP_EDGE, perm[k], p);
			if (n <= 40 && $urandom_range(0, 14) == 0)
				send(OP_W'($urandom_range(0, 3)), pick_node(n), pick_node(n));
		end
	endtask

	task automatic ask_paths(int n, int cnt);
		for (int k = 0; k < cnt; k++)
			if ($urandom_range(0, 9) == 0)
				send($urandom_range(0, 1) ? OP_UNUSED : OP_QUERY, pick_node(n), pick_node(n));
			else
				send(OP_QUERY, $urandom_range(1, n), $urandom_range(1, n));
	endtask

	// Receiver: random stalls, plus one long hold so the engine backs up.
	initial begin
		int g;
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= 40) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				g = gap_len();
				out_stall <= (g != 0);
				repeat (g == 0 ? $urandom_range(1, 20) : g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(status, ancestor, path_nodes);
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int n;
		sb = new();
		requests_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_EDGE;
		node_a = '0;
		node_b = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);

		// Directed: unbuilt query, unused op, bad nodes, self-loop, range extremes.
		send(OP_QUERY, 1, 1);
		send(OP_UNUSED, 1, 1);
		send(OP_EDGE, 0, 1);
		send(OP_EDGE, 1, 2);
		send(OP_EDGE, 1, 1);
		send(OP_BUILD, 0, 0);
		send(OP_QUERY, 1, 1);
		send(OP_QUERY, 2, 1);
		send(OP_QUERY, 1, 0);
		write_count(1024);
		send(OP_QUERY, 1, 1);
		send(OP_EDGE, 1024, 1);
		send(OP_EDGE, 2047, 1);
		send(OP_EDGE, 1025, 1024);
		send(OP_EDGE, 1024, 512);
		send(OP_BUILD, 2047, 2047);
		send(OP_QUERY, 1024, 1);
		send(OP_QUERY, 512, 1024);
		send(OP_QUERY, 512, 3);
		send(OP_QUERY, 1024, 1024);
		send(OP_QUERY, 1025, 1);
		write_count(0);
		send(OP_QUERY, 1, 1);
		write_count(2047);
		send(OP_BUILD, 0, 0);
		send(OP_QUERY, 1024, 1);

		// Random phases on small trees, with edges after build and occasional rebuilds.
		for (int ph = 0; ph < 3; ph++) begin
			n = (ph == 0) ? 2 : $urandom_range(3, 40);
			write_count(n);
			grow_tree(n, n - 1, (ph % 2) ? 3 : 0);
			send(OP_BUILD, pick_node(n), pick_node(n));
			ask_paths(n, $urandom_range(15, 25));
			send(OP_EDGE, pick_node(n), pick_node(n));
			ask_paths(n, 5);
			if ($urandom_range(0, 2) == 0) begin
				send(OP_BUILD, 0, 0);
				ask_paths(n, 10);
			end
		end

		// Full range: a deep tree that runs the edge store out, then queries.
		write_count(1024);
		grow_tree(1024, 1023, 4);
		send(OP_EDGE, 1, 2);
		send(OP_EDGE, 1024, 1023);
		send(OP_BUILD, 0, 0);
		ask_paths(1024, 40);

		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

@@ sim.f @@
src/tlca_pkg.sv
src/tlca_ram.sv
src/tree_lca_path_length.sv
tb/sv/testbench.sv
